/* src/fsl_pkg.sv */
`default_nettype none
package fsl_pkg;

    localparam int SENSOR_COUNT = 26;
    localparam int FINGER_COUNT = 10;
    localparam int PALM_SIDE    = 4;

    localparam int CHAN_W    = 5;
    localparam int SAMPLE_W  = 24;
    localparam int FORCE_W   = 40;
    localparam int DIFF_W    = 25;
    localparam int BIAS_W    = 21;
    localparam int GAIN_W    = 22;
    localparam int RATE_W    = 23;
    localparam int FRAC_W    = 20;
    localparam int X_W       = 26;
    localparam int N_W       = X_W - FRAC_W;
    localparam int TERM_W    = 31;
    localparam int Y_W       = 30;
    localparam int SUM_W     = 33;
    localparam int FEXP_W    = SUM_W - 10;
    localparam int K_W       = 4;
    localparam int MUL_A_W   = 40;
    localparam int MUL_B_W   = 32;
    localparam int MUL_SEG_W = 20;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int PADDR_W   = 3;

    localparam int TAYLOR_TERMS = 13;
    localparam int N_MAX        = 16;
    localparam int SRC_A        = 20;
    localparam int SRC_B        = 21;
    localparam int DST_A        = 24;
    localparam int DST_B        = 25;

    localparam logic [FORCE_W-1:0] FORCE_MAX = '1;

    localparam logic REG_CAL = 1'b0;
    localparam logic REG_SUB = 1'b1;

    function automatic logic [BIAS_W-1:0] q20b(input int unsigned n);
        return BIAS_W'((64'(n) * 64'd1048576 + 64'd5000) / 64'd10000);
    endfunction

    function automatic logic [RATE_W-1:0] q20r(input int unsigned n);
        return RATE_W'((64'(n) * 64'd1048576 + 64'd5000) / 64'd10000);
    endfunction

    function automatic logic [GAIN_W-1:0] q16g(input int unsigned n);
        return GAIN_W'((64'(n) * 64'd65536 + 64'd5000) / 64'd10000);
    endfunction

    localparam logic [BIAS_W-1:0] BIAS_ROM [32] = '{
        q20b(11075), q20b(11075), q20b(11075), q20b(9650),  q20b(15100),
        q20b(12300), q20b(12950), q20b(15600), q20b(12300), q20b(12000),
        q20b(9624),  q20b(8556),  q20b(8556),  q20b(14423),
        q20b(11704), q20b(8844),  q20b(8844),  q20b(13550),
        q20b(11704), q20b(8844),  q20b(8844),  q20b(13550),
        q20b(15004), q20b(13704), q20b(11704), q20b(11235),
        '0, '0, '0, '0, '0, '0
    };

    localparam logic [GAIN_W-1:0] GAIN_ROM [32] = '{
        q16g(26179),  q16g(26179),  q16g(26179),  q16g(28000),  q16g(28570),
        q16g(26179),  q16g(26179),  q16g(26179),  q16g(26179),  q16g(26179),
        q16g(170291), q16g(155607), q16g(155607), q16g(384854),
        q16g(150423), q16g(150737), q16g(150737), q16g(120448),
        q16g(150423), q16g(150737), q16g(150737), q16g(100582),
        q16g(150423), q16g(150423), q16g(150423), q16g(150423),
        '0, '0, '0, '0, '0, '0
    };

    localparam logic [RATE_W-1:0] RATE_ROM [32] = '{
        q20r(36545), q20r(36740), q20r(35560), q20r(39893), q20r(49741),
        q20r(42741), q20r(39741), q20r(39741), q20r(45741), q20r(41741),
        q20r(30775), q20r(36000), q20r(35000), q20r(47553),
        q20r(37541), q20r(28864), q20r(29864), q20r(50022),
        q20r(34541), q20r(28864), q20r(29864), q20r(50022),
        q20r(37841), q20r(38841), q20r(29864), q20r(50022),
        '0, '0, '0, '0, '0, '0
    };

    // round(e^n * 2^16)
    function automatic logic [FORCE_W-1:0] exp_int(input logic [4:0] n);
        logic [FORCE_W-1:0] e;
        case (n)
            5'd0:    e = 40'd65536;
            5'd1:    e = 40'd178145;
            5'd2:    e = 40'd484250;
            5'd3:    e = 40'd1316326;
            5'd4:    e = 40'd3578144;
            5'd5:    e = 40'd9726405;
            5'd6:    e = 40'd26439109;
            5'd7:    e = 40'd71868951;
            5'd8:    e = 40'd195360063;
            5'd9:    e = 40'd531043708;
            5'd10:   e = 40'd1443526462;
            5'd11:   e = 40'd3923911751;
            5'd12:   e = 40'd10666298010;
            5'd13:   e = 40'd28994004059;
            5'd14:   e = 40'd78813874367;
            5'd15:   e = 40'd214238322522;
            5'd16:   e = 40'd582360139072;
            default: e = '0;
        endcase
        return e;
    endfunction

    // floor(2^31 / k)
    function automatic logic [MUL_B_W-1:0] recip(input logic [K_W-1:0] k);
        logic [MUL_B_W-1:0] m;
        case (k)
            4'd1:    m = 32'd2147483648;
            4'd2:    m = 32'd1073741824;
            4'd3:    m = 32'd715827882;
            4'd4:    m = 32'd536870912;
            4'd5:    m = 32'd429496729;
            4'd6:    m = 32'd357913941;
            4'd7:    m = 32'd306783378;
            4'd8:    m = 32'd268435456;
            4'd9:    m = 32'd238609294;
            4'd10:   m = 32'd214748364;
            4'd11:   m = 32'd195225786;
            4'd12:   m = 32'd178956970;
            4'd13:   m = 32'd165191049;
            default: m = '0;
        endcase
        return m;
    endfunction

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_CAL, OP_ZERO, OP_SAT,
        OP_MUL_X, OP_TAKE_X, OP_MUL_P, OP_TAKE_P,
        OP_MUL_T, OP_TAKE_T, OP_MUL_Q, OP_TAKE_Q, OP_FIX,
        OP_MUL_F, OP_TAKE_F
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CAL, ST_CHECK_D, ST_WAIT_X, ST_CHECK_N, ST_WAIT_P,
        ST_CHECK_P, ST_MUL_T, ST_WAIT_T, ST_MUL_Q, ST_WAIT_Q, ST_FIX,
        ST_MUL_F, ST_WAIT_F, ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic d_pos;
        logic n_big;
        logic p_big;
        logic k_last;
        logic mul_done;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

/* src/fsr_scan_exp_linearizer.sv */
`default_nettype none
// Force-sensor scan linearizer. Each input transaction is one ADC sample for
// the current scan channel (10 finger channels, then a 4x4 palm grid); each
// gives exactly one result with the channel, the force c1*exp(c2*(v-bias))
// in Q24.16 (zero for a non-positive difference), and the mux/ADC selects
// for the next sample. A sample is taken only when idle, after the previous
// result is written to the result register, where it may wait for
// out_ready. For a positive difference the fractional exponent is a series
// of 13 terms after the leading one, each using the single two-segment
// multiplier twice (term product, then reciprocal divide) plus a correction
// step. Non-positive differences and calibration mode skip the series; a
// clipped integer exponent or gain product saturates the force.
// Registers: 0x0 calibration_mode, 0x4 substitute_last_pair (reset 1).
module fsr_scan_exp_linearizer
    import fsl_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [PADDR_W-1:0]         paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] sample_volts,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [CHAN_W-1:0]               sensor_channel,
    output logic [FORCE_W-1:0]              force_value,
    output logic                            force_saturated,
    output logic signed [SAMPLE_W-1:0]      passthrough_volts,
    output logic                            next_adc_input,
    output logic [3:0]                      next_finger_mux,
    output logic [1:0]                      next_palm_row,
    output logic [1:0]                      next_palm_col,
    output logic                            last_in_scan
);

    logic    cal_reg, cal_next;
    logic    sub_reg, sub_next;
    logic    wr_en;
    dp_cmd_t cmd;
    dp_sts_t sts;

    always_comb
    begin
        wr_en    = psel && penable && pwrite;
        cal_next = cal_reg;
        sub_next = sub_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_CAL: cal_next = pwdata[0];
                REG_SUB: sub_next = pwdata[0];
                default: cal_next = cal_reg;
            endcase
        end
        unique case (paddr[2])
            REG_CAL: prdata = {31'b0, cal_reg};
            REG_SUB: prdata = {31'b0, sub_reg};
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= 1'b0;
            sub_reg <= 1'b1;
        end
        else
        begin
            cal_reg <= cal_next;
            sub_reg <= sub_next;
        end
    end

    fsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cal_mode (cal_reg),
        .sts      (sts),
        .cmd      (cmd)
    );

    fsl_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .sample_volts      (sample_volts),
        .cal_mode          (cal_reg),
        .sub_pair          (sub_reg),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .sensor_channel    (sensor_channel),
        .force_value       (force_value),
        .force_saturated   (force_saturated),
        .passthrough_volts (passthrough_volts),
        .next_adc_input    (next_adc_input),
        .next_finger_mux   (next_finger_mux),
        .next_palm_row     (next_palm_row),
        .next_palm_col     (next_palm_col),
        .last_in_scan      (last_in_scan)
    );

endmodule
`default_nettype wire

/* src/fsl_mul.sv */
`default_nettype none
module fsl_mul
    import fsl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    done,
    output logic [PROD_W-1:0]       prod
);

    localparam int PART_W = MUL_SEG_W + MUL_B_W;

    logic                          phase_reg, phase_next;
    logic                          done_reg, done_next;
    logic [MUL_A_W-MUL_SEG_W-1:0]  hi_reg, hi_next;
    logic [MUL_B_W-1:0]            b_reg, b_next;
    logic [PROD_W-1:0]             acc_reg, acc_next;
    logic [PART_W-1:0]             lo_prod;
    logic [PART_W-1:0]             hi_prod;

    // low segment on start, high segment in the cycle after
    always_comb
    begin
        lo_prod    = PART_W'(a[MUL_SEG_W-1:0]) * PART_W'(b);
        hi_prod    = PART_W'(hi_reg) * PART_W'(b_reg);
        phase_next = start;
        done_next  = phase_reg;
        hi_next    = start ? a[MUL_A_W-1:MUL_SEG_W] : hi_reg;
        b_next     = start ? b : b_reg;
        if (start)
        begin
            acc_next = PROD_W'(lo_prod);
        end
        else if (phase_reg)
        begin
            acc_next = acc_reg + (PROD_W'(hi_prod) << MUL_SEG_W);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) start |-> ##2 done)
        else $error("multiplier result not ready two cycles after start");
`endif

endmodule
`default_nettype wire

/* src/fsl_dp.sv */
`default_nettype none
module fsl_dp
    import fsl_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    cmd,
    output dp_sts_t                         sts,
    input  wire logic signed [SAMPLE_W-1:0] sample_volts,
    input  wire logic                       cal_mode,
    input  wire logic                       sub_pair,
    input  wire logic                       out_ready,
    output logic                            out_valid,
    output logic [CHAN_W-1:0]               sensor_channel,
    output logic [FORCE_W-1:0]              force_value,
    output logic                            force_saturated,
    output logic signed [SAMPLE_W-1:0]      passthrough_volts,
    output logic                            next_adc_input,
    output logic [3:0]                      next_finger_mux,
    output logic [1:0]                      next_palm_row,
    output logic [1:0]                      next_palm_col,
    output logic                            last_in_scan
);

    // scan and held state
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [1:0]          row_reg, row_next;
    logic [1:0]          col_reg, col_next;
    logic [FORCE_W-1:0]  held_a_reg, held_a_next;
    logic [FORCE_W-1:0]  held_b_reg, held_b_next;
    logic [K_W-1:0]      k_reg, k_next;

    // working registers
    logic [DIFF_W-1:0]   d_reg, d_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic [FORCE_W-1:0]  p_reg, p_next;
    logic                pbig_reg, pbig_next;
    logic [TERM_W-1:0]   term_reg, term_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [Y_W-1:0]      y_reg, y_next;
    logic [Y_W-1:0]      q0_reg, q0_next;
    logic [FORCE_W-1:0]  force_reg, force_next;
    logic                fsat_reg, fsat_next;
    logic [SAMPLE_W-1:0] pass_reg, pass_next;
    logic                cal_reg, cal_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]   o_chan_reg, o_chan_next;
    logic [FORCE_W-1:0]  o_force_reg, o_force_next;
    logic                o_sat_reg, o_sat_next;
    logic [SAMPLE_W-1:0] o_pass_reg, o_pass_next;
    logic                o_adc_reg, o_adc_next;
    logic [3:0]          o_mux_reg, o_mux_next;
    logic [1:0]          o_row_reg, o_row_next;
    logic [1:0]          o_col_reg, o_col_next;
    logic                o_last_reg, o_last_next;

    logic                mul_start;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_done;
    logic [PROD_W-1:0]   prod;

    logic [DIFF_W-1:0]   d_calc;
    logic [N_W-1:0]      n_int;
    logic [FRAC_W-1:0]   r_frac;
    logic [Y_W+K_W-1:0]  q0k;
    logic [Y_W+K_W-1:0]  rem;
    logic [Y_W-1:0]      q_fix;
    logic [SUM_W-1:0]    sum_rnd;
    logic [FEXP_W-1:0]   fexp;
    logic                is_last;
    logic [CHAN_W-1:0]   nxt;
    logic                nxt_palm;

    fsl_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    always_comb
    begin
        d_calc  = {sample_volts[SAMPLE_W-1], sample_volts}
                  - {{(DIFF_W-BIAS_W){1'b0}}, BIAS_ROM[chan_reg]};
        n_int   = x_reg[X_W-1:FRAC_W];
        r_frac  = x_reg[FRAC_W-1:0];
        // reciprocal quotient is low by at most one: fix with one compare
        q0k     = (Y_W+K_W)'(q0_reg) * (Y_W+K_W)'(k_reg);
        rem     = (Y_W+K_W)'(y_reg) - q0k;
        q_fix   = q0_reg + Y_W'(rem >= (Y_W+K_W)'(k_reg));
        sum_rnd = sum_reg + SUM_W'(512);
        fexp    = sum_rnd[SUM_W-1:10];
    end

    always_comb
    begin
        sts.d_pos    = !d_reg[DIFF_W-1] && (d_reg != '0);
        sts.n_big    = n_int > N_W'(N_MAX);
        sts.p_big    = pbig_reg;
        sts.k_last   = k_reg == K_W'(TAYLOR_TERMS);
        sts.mul_done = mul_done;
        sts.out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        d_next     = d_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        pbig_next  = pbig_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        k_next     = k_reg;
        y_next     = y_reg;
        q0_next    = q0_reg;
        force_next = force_reg;
        fsat_next  = fsat_reg;
        pass_next  = pass_reg;
        cal_next   = cal_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (cmd.op)
            OP_IDLE:
            begin
            end
            OP_LOAD:
            begin
                d_next    = d_calc;
                pass_next = sample_volts;
                cal_next  = cal_mode;
            end
            OP_CAL, OP_ZERO:
            begin
                force_next = '0;
                fsat_next  = 1'b0;
            end
            OP_SAT:
            begin
                force_next = FORCE_MAX;
                fsat_next  = 1'b1;
            end
            OP_MUL_X:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(d_reg[DIFF_W-2:0]);
                mul_b     = MUL_B_W'(RATE_ROM[chan_reg]);
            end
            OP_TAKE_X:
            begin
                x_next = prod[X_W+FRAC_W-1:FRAC_W];
            end
            OP_MUL_P:
            begin
                mul_start = 1'b1;
                mul_a     = exp_int(n_int[4:0]);
                mul_b     = MUL_B_W'(GAIN_ROM[chan_reg]);
            end
            OP_TAKE_P:
            begin
                p_next    = prod[FORCE_W+15:16];
                pbig_next = |prod[PROD_W-1:FORCE_W+16];
                term_next = TERM_W'(1) << 30;
                sum_next  = SUM_W'(1) << 30;
                k_next    = K_W'(1);
            end
            OP_MUL_T:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(term_reg);
                mul_b     = MUL_B_W'({r_frac, 10'b0});
            end
            OP_TAKE_T:
            begin
                y_next = prod[Y_W+29:30];
            end
            OP_MUL_Q:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(y_reg);
                mul_b     = recip(k_reg);
            end
            OP_TAKE_Q:
            begin
                q0_next = prod[Y_W+30:31];
            end
            OP_FIX:
            begin
                term_next = TERM_W'(q_fix);
                sum_next  = sum_reg + SUM_W'(q_fix);
                k_next    = k_reg + K_W'(1);
            end
            OP_MUL_F:
            begin
                mul_start = 1'b1;
                mul_a     = p_reg;
                mul_b     = MUL_B_W'(fexp);
            end
            OP_TAKE_F:
            begin
                if (|prod[PROD_W-1:FORCE_W+FRAC_W])
                begin
                    force_next = FORCE_MAX;
                    fsat_next  = 1'b1;
                end
                else
                begin
                    force_next = prod[FORCE_W+FRAC_W-1:FRAC_W];
                    fsat_next  = 1'b0;
                end
            end
        endcase
    end

    // result transaction, scan advance and next selects
    always_comb
    begin
        is_last  = chan_reg == CHAN_W'(SENSOR_COUNT - 1);
        nxt      = is_last ? '0 : chan_reg + CHAN_W'(1);
        nxt_palm = nxt >= CHAN_W'(FINGER_COUNT);

        chan_next   = chan_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        held_a_next = held_a_reg;
        held_b_next = held_b_reg;

        o_chan_next  = o_chan_reg;
        o_force_next = o_force_reg;
        o_sat_next   = o_sat_reg;
        o_pass_next  = o_pass_reg;
        o_adc_next   = o_adc_reg;
        o_mux_next   = o_mux_reg;
        o_row_next   = o_row_reg;
        o_col_next   = o_col_reg;
        o_last_next  = o_last_reg;

        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (cal_reg)
            begin
                chan_next    = '0;
                row_next     = '0;
                col_next     = '0;
                o_chan_next  = '0;
                o_force_next = '0;
                o_sat_next   = 1'b0;
                o_pass_next  = pass_reg;
                o_adc_next   = 1'b0;
                o_mux_next   = '0;
                o_row_next   = '0;
                o_col_next   = '0;
                o_last_next  = 1'b0;
            end
            else
            begin
                if (!nxt_palm || nxt == CHAN_W'(FINGER_COUNT))
                begin
                    row_next = '0;
                    col_next = '0;
                end
                else if (col_reg == 2'(PALM_SIDE - 1))
                begin
                    row_next = row_reg + 2'd1;
                    col_next = '0;
                end
                else
                begin
                    col_next = col_reg + 2'd1;
                end
                if (chan_reg == CHAN_W'(SRC_A))
                begin
                    held_a_next = force_reg;
                end
                if (chan_reg == CHAN_W'(SRC_B))
                begin
                    held_b_next = force_reg;
                end
                o_force_next = force_reg;
                o_sat_next   = fsat_reg;
                if (sub_pair && chan_reg == CHAN_W'(DST_A))
                begin
                    o_force_next = held_a_reg;
                    o_sat_next   = held_a_reg == FORCE_MAX;
                end
                else if (sub_pair && chan_reg == CHAN_W'(DST_B))
                begin
                    o_force_next = held_b_reg;
                    o_sat_next   = held_b_reg == FORCE_MAX;
                end
                chan_next   = nxt;
                o_chan_next = chan_reg;
                o_pass_next = '0;
                o_adc_next  = nxt_palm;
                o_mux_next  = nxt_palm ? 4'd0 : nxt[3:0];
                o_row_next  = row_next;
                o_col_next  = col_next;
                o_last_next = is_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg      <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            held_a_reg    <= '0;
            held_b_reg    <= '0;
            k_reg         <= K_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chan_reg      <= chan_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            held_a_reg    <= held_a_next;
            held_b_reg    <= held_b_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        x_reg       <= x_next;
        p_reg       <= p_next;
        pbig_reg    <= pbig_next;
        term_reg    <= term_next;
        sum_reg     <= sum_next;
        y_reg       <= y_next;
        q0_reg      <= q0_next;
        force_reg   <= force_next;
        fsat_reg    <= fsat_next;
        pass_reg    <= pass_next;
        cal_reg     <= cal_next;
        o_chan_reg  <= o_chan_next;
        o_force_reg <= o_force_next;
        o_sat_reg   <= o_sat_next;
        o_pass_reg  <= o_pass_next;
        o_adc_reg   <= o_adc_next;
        o_mux_reg   <= o_mux_next;
        o_row_reg   <= o_row_next;
        o_col_reg   <= o_col_next;
        o_last_reg  <= o_last_next;
    end

    assign out_valid         = out_valid_reg;
    assign sensor_channel    = o_chan_reg;
    assign force_value       = o_force_reg;
    assign force_saturated   = o_sat_reg;
    assign passthrough_volts = o_pass_reg;
    assign next_adc_input    = o_adc_reg;
    assign next_finger_mux   = o_mux_reg;
    assign next_palm_row     = o_row_reg;
    assign next_palm_col     = o_col_reg;
    assign last_in_scan      = o_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        chan_reg <= CHAN_W'(SENSOR_COUNT - 1))
        else $error("scan position beyond last channel");
    assert property (@(posedge clk) disable iff (!rst_n)
        k_reg != '0 && k_reg <= K_W'(TAYLOR_TERMS + 1))
        else $error("series index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_last_reg |-> o_chan_reg == CHAN_W'(SENSOR_COUNT - 1))
        else $error("end of scan flagged on wrong channel");
`endif

endmodule
`default_nettype wire

/* src/fsl_ctrl.sv */
`default_nettype none
module fsl_ctrl
    import fsl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    cal_mode,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    state_next = cal_mode ? ST_CAL : ST_CHECK_D;
                end
            ST_CAL:     state_next = ST_EMIT;
            ST_CHECK_D: state_next = sts.d_pos ? ST_WAIT_X : ST_EMIT;
            ST_WAIT_X:  if (sts.mul_done) state_next = ST_CHECK_N;
            ST_CHECK_N: state_next = sts.n_big ? ST_EMIT : ST_WAIT_P;
            ST_WAIT_P:  if (sts.mul_done) state_next = ST_CHECK_P;
            ST_CHECK_P: state_next = sts.p_big ? ST_EMIT : ST_MUL_T;
            ST_MUL_T:   state_next = ST_WAIT_T;
            ST_WAIT_T:  if (sts.mul_done) state_next = ST_MUL_Q;
            ST_MUL_Q:   state_next = ST_WAIT_Q;
            ST_WAIT_Q:  if (sts.mul_done) state_next = ST_FIX;
            ST_FIX:     state_next = sts.k_last ? ST_MUL_F : ST_MUL_T;
            ST_MUL_F:   state_next = ST_WAIT_F;
            ST_WAIT_F:  if (sts.mul_done) state_next = ST_EMIT;
            ST_EMIT:    if (sts.out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_IDLE;
        cmd.emit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_CAL:     cmd.op = OP_CAL;
            ST_CHECK_D: cmd.op = sts.d_pos ? OP_MUL_X : OP_ZERO;
            ST_WAIT_X:  if (sts.mul_done) cmd.op = OP_TAKE_X;
            ST_CHECK_N: cmd.op = sts.n_big ? OP_SAT : OP_MUL_P;
            ST_WAIT_P:  if (sts.mul_done) cmd.op = OP_TAKE_P;
            ST_CHECK_P: if (sts.p_big) cmd.op = OP_SAT;
            ST_MUL_T:   cmd.op = OP_MUL_T;
            ST_WAIT_T:  if (sts.mul_done) cmd.op = OP_TAKE_T;
            ST_MUL_Q:   cmd.op = OP_MUL_Q;
            ST_WAIT_Q:  if (sts.mul_done) cmd.op = OP_TAKE_Q;
            ST_FIX:     cmd.op = OP_FIX;
            ST_MUL_F:   cmd.op = OP_MUL_F;
            ST_WAIT_F:  if (sts.mul_done) cmd.op = OP_TAKE_F;
            ST_EMIT:    cmd.emit = sts.out_free;
            default:    cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) cmd.emit |-> sts.out_free)
        else $error("result written while output register is held");
`endif

endmodule
`default_nettype wire
